// ===== src/tfsr_pkg.sv =====
package tfsr_pkg;

    // Buffer and tag ring geometry
    localparam int BUF_ADDR_BITS = 10;
    localparam int TAG_BITS      = 4;
    localparam int NSLOTS        = 1 << TAG_BITS;
    localparam int BUF_WORDS     = 1 << BUF_ADDR_BITS;

    // Operation codes
    localparam logic [1:0] OP_PREPARE  = 2'd0;
    localparam logic [1:0] OP_ENQUEUE  = 2'd1;
    localparam logic [1:0] OP_PROGRESS = 2'd2;
    localparam logic [1:0] OP_RELEASE  = 2'd3;

    // Slot status codes
    localparam logic [1:0] ST_UNUSED  = 2'd0;
    localparam logic [1:0] ST_PREPARE = 2'd1;
    localparam logic [1:0] ST_SENDING = 2'd2;
    localparam logic [1:0] ST_WAITACK = 2'd3;

    typedef struct packed {
        logic [1:0]               op;
        logic [BUF_ADDR_BITS-1:0] frame_words;
        logic [7:0]               seq_number;
        logic [TAG_BITS-1:0]      slot_tag;
        logic [31:0]              now_tick;
        logic [TAG_BITS-1:0]      done_tag;
    } t_in_beat;

    typedef struct packed {
        logic [TAG_BITS-1:0]      given_tag;
        logic [BUF_ADDR_BITS:0]   free_words;
        logic                     cmd_valid;
        logic [TAG_BITS-1:0]      cmd_tag;
        logic [BUF_ADDR_BITS-1:0] cmd_len;
        logic [BUF_ADDR_BITS-1:0] cmd_start;
        logic [TAG_BITS:0]        odd_states;
    } t_out_beat;

    // Per-slot frame record
    typedef struct packed {
        logic [BUF_ADDR_BITS-1:0] slot_words;
        logic [BUF_ADDR_BITS-1:0] slot_begin;
        logic [BUF_ADDR_BITS-1:0] slot_end;
    } t_slot_rec;

    // Status memory ports
    typedef struct packed {
        logic                en;
        logic [TAG_BITS-1:0] tag;
    } t_st_rd;

    typedef struct packed {
        logic                en;
        logic [TAG_BITS-1:0] tag;
        logic [1:0]          status;
    } t_st_wr;

endpackage

// ===== src/tx_frame_slot_ring_tracker.sv =====
// Channel  Direction  Handshake                 Beat
// in       input      i_in_valid / o_in_stall   i_in  (t_in_beat)
// out      output     o_out_valid / i_out_stall o_out (t_out_beat)
//
// One item at a time. Prepare goes to the done step, enqueue and release first
// do one record-memory read, progress walks n tags (0 to 15): the status memory
// reads each tag and writes back the ones found sending as waiting for the ack.
// Reset is synchronous; pointers, the next tag and status valid bits clear at once, the completed tag sets to all ones.
// A finished beat waits in the output register; while it is stalled the
// next item is taken and held in its final step until the register frees.
module tx_frame_slot_ring_tracker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tfsr_pkg::t_in_beat  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tfsr_pkg::t_out_beat o_out
);
    import tfsr_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]               r_state, n_state;
    logic [BUF_ADDR_BITS-1:0] r_top, n_top;
    logic [BUF_ADDR_BITS-1:0] r_bot, n_bot;
    logic [TAG_BITS-1:0]      r_next_tag, n_next_tag;
    logic [TAG_BITS-1:0]      r_hw_done, n_hw_done;
    logic                     r_chk_valid, n_chk_valid;
    logic                     r_out_valid, n_out_valid;
    logic [TAG_BITS-1:0]      r_walk, n_walk;
    logic [TAG_BITS:0]        r_odd, n_odd;
    t_out_beat                r_out, n_out;
    logic [1:0]               r_op;
    logic [TAG_BITS-1:0]      r_given;
    logic [TAG_BITS-1:0]      r_stop;
    logic [TAG_BITS-1:0]      r_chk_tag;
    t_slot_rec                r_rec_mem [NSLOTS];
    t_slot_rec                r_rec_q;

    logic                     in_acc;
    logic                     out_free;
    logic [BUF_ADDR_BITS-1:0] top_add;
    logic [BUF_ADDR_BITS:0]   free_w;
    logic [1:0]               st_rd;
    t_st_rd                   st_rd_port;
    t_st_wr                   st_wr_port;
    t_out_beat                res;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign top_add     = r_top + i_in.frame_words;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Status memory
    tfsr_status_mem u_status (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd        (st_rd_port),
        .o_rd_status (st_rd),
        .i_wr        (st_wr_port)
    );

    // Read the next walked tag
    always_comb begin
        st_rd_port.en  = (r_state == S_WALK) && (r_walk != r_stop);
        st_rd_port.tag = r_walk;
    end

    // Pick the status write: command at accept, or walk write-back
    always_comb begin
        st_wr_port.en     = 1'b0;
        st_wr_port.tag    = i_in.slot_tag;
        st_wr_port.status = ST_UNUSED;
        if (in_acc) begin
            case (i_in.op)
                OP_PREPARE: begin
                    st_wr_port.en     = 1'b1;
                    st_wr_port.tag    = r_next_tag;
                    st_wr_port.status = ST_PREPARE;
                end
                OP_ENQUEUE: begin
                    st_wr_port.en     = 1'b1;
                    st_wr_port.status = ST_SENDING;
                end
                OP_RELEASE: begin
                    st_wr_port.en     = 1'b1;
                    st_wr_port.status = ST_UNUSED;
                end
                default: begin
                    st_wr_port.en = 1'b0;
                end
            endcase
        end else if (r_state == S_WALK && r_chk_valid && st_rd == ST_SENDING) begin
            st_wr_port.en     = 1'b1;
            st_wr_port.tag    = r_chk_tag;
            st_wr_port.status = ST_WAITACK;
        end
    end

    // Record memory: write on prepare, read on enqueue and release
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.op == OP_PREPARE) begin
            r_rec_mem[r_next_tag] <= '{slot_words: i_in.frame_words,
                                       slot_begin: r_top,
                                       slot_end:   top_add};
        end
        if (in_acc && (i_in.op == OP_ENQUEUE || i_in.op == OP_RELEASE)) begin
            r_rec_q <= r_rec_mem[i_in.slot_tag];
        end
    end

    // Free space from the current pointers
    always_comb begin
        if (r_top >= r_bot) begin
            free_w = (BUF_ADDR_BITS+1)'(BUF_WORDS) - {1'b0, r_top} + {1'b0, r_bot};
        end else begin
            free_w = {1'b0, r_bot} - {1'b0, r_top} - (BUF_ADDR_BITS+1)'(1);
        end
    end

    // Assemble the result beat
    always_comb begin
        res.given_tag  = r_given;
        res.free_words = free_w;
        res.cmd_valid  = (r_op == OP_ENQUEUE);
        res.cmd_tag    = (r_op == OP_ENQUEUE) ? r_given : '0;
        res.cmd_len    = (r_op == OP_ENQUEUE) ? r_rec_q.slot_words : '0;
        res.cmd_start  = (r_op == OP_ENQUEUE) ? r_rec_q.slot_begin : '0;
        res.odd_states = (r_op == OP_PROGRESS) ? r_odd : '0;
    end

    // Sequence one item
    always_comb begin
        n_state     = r_state;
        n_top       = r_top;
        n_bot       = r_bot;
        n_next_tag  = r_next_tag;
        n_hw_done   = r_hw_done;
        n_chk_valid = 1'b0;
        n_walk      = r_walk;
        n_odd       = r_odd;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in.op)
                        OP_PREPARE: begin
                            n_top      = top_add;
                            n_next_tag = r_next_tag + TAG_BITS'(1);
                            n_state    = S_DONE;
                        end
                        OP_PROGRESS: begin
                            n_hw_done = i_in.done_tag;
                            n_walk    = r_hw_done + TAG_BITS'(1);
                            n_odd     = '0;
                            n_state   = S_WALK;
                        end
                        default: begin
                            n_state = S_READ;
                        end
                    endcase
                end
            end
            S_READ: begin
                if (r_op == OP_RELEASE) begin
                    n_bot = r_rec_q.slot_end;
                end
                n_state = S_DONE;
            end
            S_WALK: begin
                if (r_chk_valid && st_rd != ST_SENDING) begin
                    n_odd = r_odd + (TAG_BITS+1)'(1);
                end
                if (r_walk != r_stop) begin
                    n_chk_valid = 1'b1;
                    n_walk      = r_walk + TAG_BITS'(1);
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_top       <= '0;
            r_bot       <= '0;
            r_next_tag  <= '0;
            r_hw_done   <= '1;
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_top       <= n_top;
            r_bot       <= n_bot;
            r_next_tag  <= n_next_tag;
            r_hw_done   <= n_hw_done;
            r_chk_valid <= n_chk_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_walk <= n_walk;
        r_odd  <= n_odd;
        r_out  <= n_out;
        if (st_rd_port.en) begin
            r_chk_tag <= r_walk;
        end
        if (in_acc) begin
            r_op   <= i_in.op;
            r_stop <= i_in.done_tag + TAG_BITS'(1);
            case (i_in.op)
                OP_PREPARE:  r_given <= r_next_tag;
                OP_PROGRESS: r_given <= i_in.done_tag;
                default:     r_given <= i_in.slot_tag;
            endcase
        end
    end

    // Checks
    a_chk_only_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk_valid |-> r_state == S_WALK)
        else $error("walk check pending outside the walk");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state != S_IDLE)
        else $error("accepted beat did not start work");

    a_cmd_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.cmd_valid |->
            o_out.cmd_tag == '0 && o_out.cmd_len == '0 && o_out.cmd_start == '0)
        else $error("command fields set without a command");

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.free_words <= (BUF_ADDR_BITS+1)'(BUF_WORDS))
        else $error("free space beyond buffer size");

    a_odd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.odd_states < (TAG_BITS+1)'(NSLOTS))
        else $error("odd count beyond walk length");

endmodule

// ===== src/tfsr_status_mem.sv =====
module tfsr_status_mem (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tfsr_pkg::t_st_rd i_rd,
    output logic [1:0]       o_rd_status,
    input  tfsr_pkg::t_st_wr i_wr
);
    import tfsr_pkg::*;

    logic [1:0]        r_mem [NSLOTS];
    logic [NSLOTS-1:0] r_vld;
    logic [1:0]        r_q;
    logic              r_q_ok;

    // Write the status array
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.tag] <= i_wr.status;
        end
    end

    // Mark written entries; an unmarked entry reads as unused
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.tag] <= 1'b1;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_q    <= r_mem[i_rd.tag];
            r_q_ok <= r_vld[i_rd.tag];
        end
    end

    assign o_rd_status = r_q_ok ? r_q : ST_UNUSED;

endmodule

// ===== tb/tx_frame_slot_ring_tracker_tb.sv =====
`timescale 1ns / 1ps

module tx_frame_slot_ring_tracker_tb;
    import tfsr_pkg::*;

    localparam int NUM_RANDOM   = 880;
    localparam int QUIET_TAIL   = 150;
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 2000;
    localparam int SHOW_MAX     = 10;

    // Mirror of the slot ring; predicts one result beat per accepted beat
    class slot_ring_board;
        logic [1:0]               slot_state [NSLOTS];
        logic [BUF_ADDR_BITS-1:0] rec_words  [NSLOTS];
        logic [BUF_ADDR_BITS-1:0] rec_begin  [NSLOTS];
        logic [BUF_ADDR_BITS-1:0] rec_end    [NSLOTS];
        logic [BUF_ADDR_BITS-1:0] top_ptr;
        logic [BUF_ADDR_BITS-1:0] bottom_ptr;
        logic [TAG_BITS-1:0]      alloc_tag;
        logic [TAG_BITS-1:0]      acked_tag;
        t_out_beat                expected_outs [$];
        int                       mismatches;

        function new();
            foreach (slot_state[i]) begin
                slot_state[i] = ST_UNUSED;
                rec_words[i]  = '0;
                rec_begin[i]  = '0;
                rec_end[i]    = '0;
            end
            top_ptr    = '0;
            bottom_ptr = '0;
            alloc_tag  = '0;
            acked_tag  = '1;
            mismatches = 0;
        endfunction

        function logic [BUF_ADDR_BITS:0] free_space();
            int words_left;
            if (top_ptr >= bottom_ptr) begin
                words_left = BUF_WORDS - int'(top_ptr) + int'(bottom_ptr);
            end else begin
                words_left = int'(bottom_ptr) - 1 - int'(top_ptr);
            end
            return words_left[BUF_ADDR_BITS:0];
        endfunction

        function void note_beat(t_in_beat b);
            t_out_beat           res;
            logic [TAG_BITS-1:0] walk;
            logic [TAG_BITS-1:0] stop_tag;
            res = '0;
            res.given_tag = b.slot_tag;
            case (b.op)
                OP_PREPARE: begin
                    res.given_tag = alloc_tag;
                    slot_state[alloc_tag] = ST_PREPARE;
                    rec_words[alloc_tag]  = b.frame_words;
                    rec_begin[alloc_tag]  = top_ptr;
                    top_ptr               = top_ptr + b.frame_words;
                    rec_end[alloc_tag]    = top_ptr;
                    alloc_tag             = alloc_tag + 1'b1;
                end
                OP_ENQUEUE: begin
                    res.cmd_valid = 1'b1;
                    res.cmd_tag   = b.slot_tag;
                    res.cmd_len   = rec_words[b.slot_tag];
                    res.cmd_start = rec_begin[b.slot_tag];
                    slot_state[b.slot_tag] = ST_SENDING;
                end
                OP_PROGRESS: begin
                    // walk from the tag after the last completed one up to done_tag
                    res.given_tag = b.done_tag;
                    walk     = acked_tag + 1'b1;
                    stop_tag = b.done_tag + 1'b1;
                    while (walk != stop_tag) begin
                        if (slot_state[walk] == ST_SENDING) begin
                            slot_state[walk] = ST_WAITACK;
                        end else begin
                            res.odd_states = res.odd_states + 1'b1;
                        end
                        walk = walk + 1'b1;
                    end
                    acked_tag = b.done_tag;
                end
                OP_RELEASE: begin
                    bottom_ptr = rec_end[b.slot_tag];
                    slot_state[b.slot_tag] = ST_UNUSED;
                end
                default: begin
                end
            endcase
            res.free_words = free_space();
            expected_outs.push_back(res);
        endfunction

        function void check_beat(t_out_beat got);
            t_out_beat want;
            if (expected_outs.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOW_MAX) begin
                    $display("%0t: result beat with nothing expected: tag=%0d free=%0d",
                             $time, got.given_tag, got.free_words);
                end
                return;
            end
            want = expected_outs.pop_front();
            if (got.given_tag !== want.given_tag || got.free_words !== want.free_words ||
                got.cmd_valid !== want.cmd_valid || got.cmd_tag !== want.cmd_tag ||
                got.cmd_len !== want.cmd_len || got.cmd_start !== want.cmd_start ||
                got.odd_states !== want.odd_states) begin
                mismatches++;
                if (mismatches <= SHOW_MAX) begin
                    $display("%0t: mismatch exp tag=%0d free=%0d cv=%0b ctag=%0d len=%0d start=%0d odd=%0d",
                             $time, want.given_tag, want.free_words, want.cmd_valid,
                             want.cmd_tag, want.cmd_len, want.cmd_start, want.odd_states);
                    $display("%0t:          got tag=%0d free=%0d cv=%0b ctag=%0d len=%0d start=%0d odd=%0d",
                             $time, got.given_tag, got.free_words, got.cmd_valid,
                             got.cmd_tag, got.cmd_len, got.cmd_start, got.odd_states);
                end
            end
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_beat  i_in;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_beat o_out;

    slot_ring_board      board;
    logic [NSLOTS-1:0]   prepared_tags = '0;
    logic [TAG_BITS-1:0] next_alloc    = '0;
    logic                quiet_mode    = 1'b0;
    logic                hold_off_req  = 1'b0;
    logic                send_idle_on  = 1'b1;
    int                  drv_fresh   [$];
    int                  drv_sending [$];
    int                  drv_acked   [$];

    tx_frame_slot_ring_tracker u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Offer one beat and hold it until accepted
    task automatic send_beat(input t_in_beat beat);
        i_in_valid <= 1'b1;
        i_in       <= beat;
        do @(posedge i_clk); while (o_in_stall);
        board.note_beat(beat);
    endtask

    task automatic issue(input logic [1:0] op, input logic [BUF_ADDR_BITS-1:0] words,
                         input logic [7:0] seq, input logic [TAG_BITS-1:0] tag,
                         input logic [31:0] tick, input logic [TAG_BITS-1:0] done);
        t_in_beat beat;
        beat.op          = op;
        beat.frame_words = words;
        beat.seq_number  = seq;
        beat.slot_tag    = tag;
        beat.now_tick    = tick;
        beat.done_tag    = done;
        // track which slots hold written data
        if (op == OP_PREPARE) begin
            prepared_tags[next_alloc] = 1'b1;
            next_alloc = next_alloc + 1'b1;
        end
        if (!quiet_mode && send_idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        send_beat(beat);
    endtask

    function automatic logic [TAG_BITS-1:0] any_prepared_tag();
        logic [TAG_BITS-1:0] t;
        t = TAG_BITS'($urandom_range(0, NSLOTS - 1));
        while (!prepared_tags[t]) t = t + 1'b1;
        return t;
    endfunction

    // Mostly short frames, now and then any length
    function automatic logic [BUF_ADDR_BITS-1:0] rand_words();
        if ($urandom_range(0, 19) == 0) begin
            return BUF_ADDR_BITS'($urandom_range(0, BUF_WORDS - 1));
        end
        return BUF_ADDR_BITS'($urandom_range(1, 120));
    endfunction

    task automatic random_step();
        int                  pick;
        int                  k;
        int                  j;
        int                  t;
        int                  outstanding;
        logic                issued;
        logic [1:0]          op;
        logic [TAG_BITS-1:0] tag;
        pick   = $urandom_range(0, 99);
        issued = 1'b0;
        if (pick < 12) begin
            // noise: any operation, progress to any tag
            op = 2'($urandom_range(0, 3));
            if ((op == OP_ENQUEUE || op == OP_RELEASE) && prepared_tags == '0) begin
                op = OP_PREPARE;
            end
            if (op == OP_ENQUEUE || op == OP_RELEASE) begin
                tag = any_prepared_tag();
            end else begin
                tag = TAG_BITS'($urandom_range(0, NSLOTS - 1));
            end
            issue(op, rand_words(), 8'($urandom), tag, $urandom,
                  TAG_BITS'($urandom_range(0, NSLOTS - 1)));
        end else begin
            // frame lifecycle: prepare, enqueue, complete, release in order
            outstanding = drv_fresh.size() + drv_sending.size() + drv_acked.size();
            pick = $urandom_range(0, 3);
            for (k = 0; k < 4 && !issued; k++) begin
                case ((pick + k) % 4)
                    0: begin
                        if (outstanding < NSLOTS - 1) begin
                            drv_fresh.push_back(int'(next_alloc));
                            issue(OP_PREPARE, rand_words(), 8'($urandom),
                                  TAG_BITS'($urandom), $urandom, TAG_BITS'($urandom));
                            issued = 1'b1;
                        end
                    end
                    1: begin
                        if (drv_fresh.size() != 0) begin
                            t = drv_fresh.pop_front();
                            drv_sending.push_back(t);
                            issue(OP_ENQUEUE, rand_words(), 8'($urandom), TAG_BITS'(t),
                                  $urandom, TAG_BITS'($urandom));
                            issued = 1'b1;
                        end
                    end
                    2: begin
                        if (drv_sending.size() != 0) begin
                            j = $urandom_range(0, drv_sending.size() - 1);
                            t = drv_sending[j];
                            repeat (j + 1) drv_acked.push_back(drv_sending.pop_front());
                            issue(OP_PROGRESS, rand_words(), 8'($urandom),
                                  TAG_BITS'($urandom), $urandom, TAG_BITS'(t));
                            issued = 1'b1;
                        end
                    end
                    default: begin
                        if (drv_acked.size() != 0) begin
                            t = drv_acked.pop_front();
                            issue(OP_RELEASE, rand_words(), 8'($urandom), TAG_BITS'(t),
                                  $urandom, TAG_BITS'($urandom));
                            issued = 1'b1;
                        end
                    end
                endcase
            end
        end
    endtask

    // Result side: check accepted beats and drive stall bursts
    initial begin : result_sink
        int   hold_left;
        int   stall_left;
        int   run_left;
        logic stall_next;
        hold_left  = 0;
        stall_left = 0;
        run_left   = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                board.check_beat(o_out);
            end
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                stall_next = 1'b1;
            end else if (run_left > 0) begin
                run_left--;
                stall_next = 1'b0;
            end else if (!quiet_mode && $urandom_range(0, 2) == 0) begin
                stall_left = $urandom_range(1, 18) - 1;
                stall_next = 1'b1;
            end else begin
                run_left   = $urandom_range(1, 30);
                stall_next = 1'b0;
            end
            i_out_stall <= stall_next;
        end
    end

    // End the run if nothing moves on either channel for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int n;
        board = new();
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in       <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // progress to the tag already completed: nothing walked
        issue(OP_PROGRESS, '0, '0, '0, '0, 4'd15);
        // progress over unused slots
        issue(OP_PROGRESS, '0, '0, 4'd15, '0, 4'd3);
        // zero-length, full-length and wrapping frames
        issue(OP_PREPARE, 10'd0, 8'd0, 4'd15, 32'hFFFF_FFFF, 4'd15);
        issue(OP_PREPARE, 10'd1023, 8'd255, 4'd0, 32'h0, 4'd0);
        issue(OP_PREPARE, 10'd5, 8'hA5, 4'd9, 32'h1234_5678, 4'd6);
        issue(OP_ENQUEUE, 10'd1023, 8'd255, 4'd0, 32'h0, 4'd15);
        issue(OP_ENQUEUE, 10'd0, 8'd0, 4'd1, 32'hFFFF_FFFF, 4'd0);
        issue(OP_ENQUEUE, 10'd512, 8'h5A, 4'd2, 32'h5A5A_A5A5, 4'd9);
        // progress wrapping around the ring
        issue(OP_PROGRESS, 10'd0, 8'd0, 4'd0, 32'h0, 4'd2);
        issue(OP_RELEASE, 10'd0, 8'd0, 4'd0, 32'h0, 4'd0);
        issue(OP_RELEASE, 10'd0, 8'd0, 4'd1, 32'h0, 4'd0);
        // act on slots whatever their state
        issue(OP_ENQUEUE, 10'd0, 8'd0, 4'd2, 32'hFFFF_FFFF, 4'd0);
        issue(OP_RELEASE, 10'd0, 8'd0, 4'd1, 32'h0, 4'd0);
        issue(OP_PROGRESS, 10'd0, 8'd0, 4'd0, 32'h0, 4'd2);
        issue(OP_PROGRESS, 10'd0, 8'd0, 4'd0, 32'h0, 4'd1);
        issue(OP_PREPARE, 10'd1023, 8'h3C, 4'd7, 32'h0, 4'd7);
        issue(OP_RELEASE, 10'd0, 8'd0, 4'd2, 32'h0, 4'd0);
        issue(OP_ENQUEUE, 10'd0, 8'd0, 4'd3, 32'h8000_0001, 4'd0);
        issue(OP_RELEASE, 10'd0, 8'd0, 4'd3, 32'h0, 4'd0);

        // hold off the receiver while beats keep coming, so the input backs up
        hold_off_req = 1'b1;
        send_idle_on = 1'b0;
        repeat (12) random_step();

        for (n = 0; n < NUM_RANDOM; n++) begin
            if (n % 64 == 0) begin
                send_idle_on = 1'($urandom_range(0, 1));
            end
            if (n == NUM_RANDOM / 2) begin
                // pause the sender until every result is back
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (board.expected_outs.size() != 0);
            end
            if (n == NUM_RANDOM - QUIET_TAIL) begin
                quiet_mode = 1'b1;
            end
            random_step();
        end

        // drain and let the block settle
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (board.expected_outs.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0 && board.expected_outs.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
